/* rtl/ght_pkg.sv */
// ght_pkg: shared constants, types and command struct for the handle table
// used by ght_ctrl, ght_datapath and generational_handle_table_unit
`default_nettype none
package ght_pkg;
   localparam int SLOTS     = 64;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int GEN_W     = 24;
   localparam int RIGHTS_W  = 8;

   localparam logic [2:0] OP_INSTALL  = 3'd0;
   localparam logic [2:0] OP_RESOLVE  = 3'd1;
   localparam logic [2:0] OP_RESTRICT = 3'd2;
   localparam logic [2:0] OP_REVOKE   = 3'd3;
   localparam logic [2:0] OP_QUERY    = 3'd4;
   localparam logic [2:0] OP_CLOSE    = 3'd5;
   localparam logic [2:0] OP_REAP     = 3'd6;

   localparam logic [2:0] KIND_TENSOR = 3'd1;
   localparam logic [2:0] KIND_ANY    = 3'd5;

   localparam logic [1:0] REG_TAG    = 2'd0;
   localparam logic [1:0] REG_MODE   = 2'd1;
   localparam logic [1:0] REG_RIGHTS = 2'd2;
   localparam logic [1:0] REG_WRITE  = 2'd3;

   typedef struct packed {
      logic [63:0]         object;
      logic [2:0]          kind;
      logic [RIGHTS_W-1:0] rights;
      logic [GEN_W-1:0]    gen;
   } row_type;

   typedef struct packed {
      logic capture;   // take the request word
      logic look;      // search flags, read the entry
      logic exec;      // evaluate, write back, load the response
   } cmd_type;
endpackage
`default_nettype wire

/* rtl/generational_handle_table_unit.sv */
// generational_handle_table_unit: top level of the capability handle table
// depends on ght_pkg, ght_ctrl and ght_datapath
//
// usage:
//   request channel req_*: valid/stall; a word is taken when req_valid is high
//   and req_stall low. each word runs one operation on the 64-entry table.
//   response channel rsp_*: exactly one response word per request, held stable
//   while rsp_stall is high.
//   csr_*: a write of domain tag, mode, rights mask or write-right mask at any
//   edge with csr_write high; user-enforced: only while no request is in flight.
// timing:
//   a request is taken in idle, the next cycle searches the flag vectors and
//   reads the entry memory, the cycle after evaluates and writes back, and the
//   response registers are loaded there and shown in the response state. an
//   item passes idle, look, exec and response states in order, one at a time.
//   req_stall stays high until the response word is taken, so a stalled
//   receiver holds off new requests.
// reset: synchronous, clears flags, counters and config to defaults; entry
//   memory needs no clearing pass (per-entry generation valid bits).
`default_nettype none
module generational_handle_table_unit import ght_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [2:0]          req_operation,
   input  wire logic [63:0]         req_handle_in,
   input  wire logic [63:0]         req_object_ref,
   input  wire logic [2:0]          req_object_kind,
   input  wire logic [RIGHTS_W-1:0] req_rights,
   input  wire logic                req_object_readonly,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_ok,
   output logic [63:0]              rsp_handle_out,
   output logic [63:0]              rsp_object_out,
   output logic [RIGHTS_W-1:0]      rsp_rights_out,
   output logic [7:0]               rsp_live_count,
   output logic [7:0]               rsp_revoked_count,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [31:0]         csr_wdata
);
   cmd_type cmd;

   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ght_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_operation       (req_operation),
      .req_handle_in       (req_handle_in),
      .req_object_ref      (req_object_ref),
      .req_object_kind     (req_object_kind),
      .req_rights          (req_rights),
      .req_object_readonly (req_object_readonly),
      .rsp_ok              (rsp_ok),
      .rsp_handle_out      (rsp_handle_out),
      .rsp_object_out      (rsp_object_out),
      .rsp_rights_out      (rsp_rights_out),
      .rsp_live_count      (rsp_live_count),
      .rsp_revoked_count   (rsp_revoked_count)
   );
endmodule
`default_nettype wire

/* rtl/ght_ctrl.sv */
// ght_ctrl: sequencer for the handle table, one request at a time
// depends on ght_pkg (cmd_type)
`default_nettype none
module ght_ctrl import ght_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output cmd_type   cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_LOOK;
         ST_LOOK: state_in = ST_EXEC;
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.look    = (state_ff == ST_LOOK);
   assign cmd.exec    = (state_ff == ST_EXEC);
endmodule
`default_nettype wire

/* rtl/ght_datapath.sv */
// ght_datapath: entry memory, flag vectors, counters, config and response regs
// depends on ght_pkg; driven by ght_ctrl commands
`default_nettype none
module ght_datapath import ght_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [31:0]         csr_wdata,
   input  wire logic [2:0]          req_operation,
   input  wire logic [63:0]         req_handle_in,
   input  wire logic [63:0]         req_object_ref,
   input  wire logic [2:0]          req_object_kind,
   input  wire logic [RIGHTS_W-1:0] req_rights,
   input  wire logic                req_object_readonly,
   output logic                     rsp_ok,
   output logic [63:0]              rsp_handle_out,
   output logic [63:0]              rsp_object_out,
   output logic [RIGHTS_W-1:0]      rsp_rights_out,
   output logic [7:0]               rsp_live_count,
   output logic [7:0]               rsp_revoked_count
);
   logic [31:0] tag_ff;
   logic [1:0]  mode_ff;
   logic [RIGHTS_W-1:0] all_ff, wr_ff;

   logic [2:0]  op_ff;
   logic [63:0] h_ff, obj_ff;
   logic [2:0]  kind_ff;
   logic [RIGHTS_W-1:0] r_ff;
   logic        ro_ff;

   row_type     mem [SLOTS];
   row_type     rd_ff;
   logic [SLOTS-1:0] occ_ff, rev_ff, ex_ff, gv_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic        hit_ff;
   logic [7:0]  live_ff, revd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff  <= 32'd1;
         mode_ff <= 2'd0;
         all_ff  <= 8'hff;
         wr_ff   <= 8'h02;
      end else if (csr_write) begin
         case (csr_index)
            REG_TAG:    tag_ff  <= csr_wdata;
            REG_MODE:   mode_ff <= csr_wdata[1:0];
            REG_RIGHTS: all_ff  <= csr_wdata[RIGHTS_W-1:0];
            REG_WRITE:  wr_ff   <= csr_wdata[RIGHTS_W-1:0];
            default:    tag_ff  <= tag_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         h_ff    <= req_handle_in;
         obj_ff  <= req_object_ref;
         kind_ff <= req_object_kind;
         r_ff    <= req_rights;
         ro_ff   <= req_object_readonly;
      end
   end

   // priority search over the flag vectors, lowest slot wins
   logic [SLOTS-1:0] free_vec, reap_vec;
   logic [SLOT_W-1:0] free_idx, reap_idx, hslot, look_slot;
   logic free_hit, reap_hit, tok_ok, look_hit;
   logic [7:0] token;

   assign free_vec = ~occ_ff & ~ex_ff;
   assign reap_vec = occ_ff & rev_ff;

   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      reap_hit = 1'b0;
      reap_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_hit = 1'b1;
            free_idx = SLOT_W'(i);
         end
         if (reap_vec[i]) begin
            reap_hit = 1'b1;
            reap_idx = SLOT_W'(i);
         end
      end
   end

   assign token  = h_ff[7:0];
   assign tok_ok = (token != 8'd0) && (token <= 8'(SLOTS));
   assign hslot  = SLOT_W'(token - 8'd1);

   always_comb begin
      case (op_ff)
         OP_INSTALL: begin
            look_slot = free_idx;
            look_hit  = free_hit;
         end
         OP_REAP: begin
            look_slot = reap_idx;
            look_hit  = reap_hit;
         end
         default: begin
            look_slot = hslot;
            look_hit  = tok_ok;
         end
      endcase
   end

   // evaluation of the operation on the fetched entry
   logic [GEN_W-1:0] gen_cur, gen_next;
   logic occ_s, rev_s, base_ok, found, found_rv;
   logic r_valid;
   logic ok_c, wr_row, do_free, do_inst, do_rev;
   logic [63:0] hout_c, oout_c;
   logic [RIGHTS_W-1:0] rout_c;
   row_type row_c;

   assign gen_cur  = gv_ff[slot_ff] ? rd_ff.gen : GEN_W'(1);
   assign gen_next = (gen_cur == {GEN_W{1'b1}}) ? '0 : gen_cur + GEN_W'(1);
   assign occ_s    = occ_ff[slot_ff];
   assign rev_s    = rev_ff[slot_ff];
   assign base_ok  = (mode_ff <= 2'd1) && (h_ff != 64'd0) && (h_ff[63:32] == tag_ff)
                     && hit_ff && occ_s && (rd_ff.object != 64'd0)
                     && (h_ff[31:8] == gen_cur);
   assign found_rv = base_ok;
   assign found    = base_ok && !rev_s;
   assign r_valid  = (r_ff != '0) && ((r_ff & ~all_ff) == '0);

   always_comb begin
      ok_c    = 1'b0;
      hout_c  = '0;
      oout_c  = '0;
      rout_c  = '0;
      wr_row  = 1'b0;
      do_free = 1'b0;
      do_inst = 1'b0;
      do_rev  = 1'b0;
      row_c   = rd_ff;
      row_c.gen = gen_cur;
      case (op_ff)
         OP_INSTALL: begin
            if (mode_ff == 2'd0 && obj_ff != 64'd0 && kind_ff != 3'd0 && kind_ff <= 3'd4
                && r_valid && !(kind_ff == KIND_TENSOR && ro_ff && (r_ff & wr_ff) != '0)
                && tag_ff != 32'd0 && hit_ff) begin
               ok_c    = 1'b1;
               do_inst = 1'b1;
               wr_row  = 1'b1;
               row_c.object = obj_ff;
               row_c.kind   = kind_ff;
               row_c.rights = r_ff;
               hout_c  = {tag_ff, gen_cur, 8'(slot_ff) + 8'd1};
               rout_c  = r_ff;
            end
         end
         OP_RESOLVE: begin
            if ((r_ff == '0 || r_valid) && found
                && (kind_ff == KIND_ANY || rd_ff.kind == kind_ff)
                && ((r_ff & rd_ff.rights) == r_ff)) begin
               ok_c   = 1'b1;
               oout_c = rd_ff.object;
               rout_c = rd_ff.rights;
            end
         end
         OP_RESTRICT: begin
            if (r_valid && found && ((r_ff & rd_ff.rights) == r_ff)) begin
               ok_c   = 1'b1;
               wr_row = 1'b1;
               row_c.rights = r_ff;
               rout_c = r_ff;
            end
         end
         OP_REVOKE: begin
            if (found_rv && !rev_s) begin
               ok_c   = 1'b1;
               do_rev = 1'b1;
               wr_row = 1'b1;
               row_c.rights = '0;
            end
         end
         OP_QUERY: begin
            if (found_rv) begin
               ok_c   = rev_s;
               rout_c = rd_ff.rights;
            end
         end
         OP_CLOSE: begin
            if (found_rv && live_ff != 8'd0) begin
               ok_c    = 1'b1;
               do_free = 1'b1;
            end
         end
         OP_REAP: begin
            if (hit_ff && rd_ff.object != 64'd0 && live_ff != 8'd0) begin
               ok_c    = 1'b1;
               do_free = 1'b1;
               oout_c  = rd_ff.object;
            end
         end
         default: ok_c = 1'b0;
      endcase
      if (do_free) begin
         wr_row = 1'b1;
         row_c.object = '0;
         row_c.kind   = '0;
         row_c.rights = '0;
         row_c.gen    = gen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.look) rd_ff <= mem[look_slot];
      if (cmd.exec && wr_row) mem[slot_ff] <= row_c;
   end

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         slot_ff <= look_slot;
         hit_ff  <= look_hit;
      end
      if (cmd.exec) begin
         rsp_ok         <= ok_c;
         rsp_handle_out <= hout_c;
         rsp_object_out <= oout_c;
         rsp_rights_out <= rout_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         rev_ff  <= '0;
         ex_ff   <= '0;
         gv_ff   <= '0;
         live_ff <= '0;
         revd_ff <= '0;
      end else if (cmd.exec) begin
         if (wr_row) gv_ff[slot_ff] <= 1'b1;
         if (do_inst) begin
            occ_ff[slot_ff] <= 1'b1;
            rev_ff[slot_ff] <= 1'b0;
            live_ff <= live_ff + 8'd1;
         end
         if (do_rev) begin
            rev_ff[slot_ff] <= 1'b1;
            revd_ff <= revd_ff + 8'd1;
         end
         if (do_free) begin
            occ_ff[slot_ff] <= 1'b0;
            rev_ff[slot_ff] <= 1'b0;
            if (gen_next == '0) ex_ff[slot_ff] <= 1'b1;
            if (rev_s && revd_ff != 8'd0) revd_ff <= revd_ff - 8'd1;
            live_ff <= live_ff - 8'd1;
         end
      end
   end

   assign rsp_live_count    = live_ff;
   assign rsp_revoked_count = revd_ff;
endmodule
`default_nettype wire

/* verif/generational_handle_table_unit_tb.sv */
// generational_handle_table_unit_tb: self-checking bench for the handle table
// depends on ght_pkg and generational_handle_table_unit; own table predictor inside
`default_nettype none
module generational_handle_table_unit_tb;
   import ght_pkg::*;

   localparam logic [2:0] OP_NONE      = 3'd7;
   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_BACKING = 3'd2;
   localparam logic [2:0] KIND_GENERIC = 3'd4;
   localparam logic [23:0] GEN_LAST    = 24'hffffff;

   typedef struct {
      logic        ok;
      logic [63:0] handle;
      logic [63:0] object;
      logic [7:0]  rights;
      logic [7:0]  live;
      logic [7:0]  revoked;
   } reply_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [2:0]          req_operation;
   logic [63:0]         req_handle_in;
   logic [63:0]         req_object_ref;
   logic [2:0]          req_object_kind;
   logic [RIGHTS_W-1:0] req_rights;
   logic                req_object_readonly;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_ok;
   logic [63:0]         rsp_handle_out;
   logic [63:0]         rsp_object_out;
   logic [RIGHTS_W-1:0] rsp_rights_out;
   logic [7:0]          rsp_live_count;
   logic [7:0]          rsp_revoked_count;
   logic                csr_write;
   logic [1:0]          csr_index;
   logic [31:0]         csr_wdata;

   // predicted table contents and registers
   logic [63:0] tbl_object[SLOTS];
   logic [23:0] tbl_gen[SLOTS];
   logic [2:0]  tbl_kind[SLOTS];
   logic [7:0]  tbl_rights[SLOTS];
   bit          tbl_occ[SLOTS];
   bit          tbl_rev[SLOTS];
   int          tbl_live;
   int          tbl_revoked;
   logic [31:0] cfg_tag;
   logic [1:0]  cfg_mode;
   logic [7:0]  cfg_all;
   logic [7:0]  cfg_write;

   reply_type   pending_replies[$];
   logic [63:0] issued_handles[$];
   bit          quiet;
   int          errors;
   int          words_sent;
   int          words_ok;
   int          settings_seen;

   generational_handle_table_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 600000);
      $display("FAIL");
      $finish;
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic bit rights_ok(input logic [7:0] r);
      return r != 0 && (r & ~cfg_all) == 0;
   endfunction

   function automatic int locate(input logic [63:0] h, input bit allow_rev);
      int s;
      if (cfg_mode > 1 || h == 0) return -1;
      if (h[63:32] != cfg_tag) return -1;
      if (h[7:0] == 0 || h[7:0] > SLOTS) return -1;
      s = h[7:0] - 1;
      if (!tbl_occ[s] || tbl_object[s] == 0) return -1;
      if (tbl_gen[s] != h[31:8]) return -1;
      if (!allow_rev && tbl_rev[s]) return -1;
      return s;
   endfunction

   function automatic void release_slot(input int s);
      if (tbl_rev[s] && tbl_revoked > 0) tbl_revoked--;
      tbl_object[s] = 0;
      tbl_kind[s]   = KIND_NONE;
      tbl_rights[s] = 0;
      tbl_occ[s]    = 0;
      tbl_rev[s]    = 0;
      // exhausted slots park at generation zero
      tbl_gen[s]    = (tbl_gen[s] == GEN_LAST) ? 24'd0 : tbl_gen[s] + 24'd1;
      if (tbl_live > 0) tbl_live--;
   endfunction

   function automatic reply_type table_step(input logic [2:0] op, input logic [63:0] h,
                                            input logic [63:0] obj, input logic [2:0] kind,
                                            input logic [7:0] r, input logic ro);
      reply_type e;
      int        s;
      bit        done;
      e = '{1'b0, 64'd0, 64'd0, 8'd0, 8'd0, 8'd0};
      done = 0;
      case (op)
         OP_INSTALL: begin
            if (cfg_mode == 0 && obj != 0 && kind != 0 && kind <= 4 && rights_ok(r)
                && !(kind == KIND_TENSOR && ro && (r & cfg_write) != 0) && cfg_tag != 0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!done && !tbl_occ[i] && tbl_gen[i] != 0) begin
                     tbl_object[i] = obj;
                     tbl_kind[i]   = kind;
                     tbl_rights[i] = r;
                     tbl_rev[i]    = 0;
                     tbl_occ[i]    = 1;
                     tbl_live++;
                     e.handle = {cfg_tag, tbl_gen[i], 8'(i + 1)};
                     e.ok     = 1;
                     e.rights = r;
                     done     = 1;
                  end
               end
            end
         end
         OP_RESOLVE: begin
            s = locate(h, 0);
            if ((r == 0 || rights_ok(r)) && s >= 0 && (kind == KIND_ANY || tbl_kind[s] == kind)
                && (r & tbl_rights[s]) == r) begin
               e.ok     = 1;
               e.object = tbl_object[s];
               e.rights = tbl_rights[s];
            end
         end
         OP_RESTRICT: begin
            s = locate(h, 0);
            if (rights_ok(r) && s >= 0 && (r & tbl_rights[s]) == r) begin
               tbl_rights[s] = r;
               e.ok     = 1;
               e.rights = r;
            end
         end
         OP_REVOKE: begin
            s = locate(h, 1);
            if (s >= 0 && !tbl_rev[s]) begin
               tbl_rev[s]    = 1;
               tbl_rights[s] = 0;
               tbl_revoked++;
               e.ok = 1;
            end
         end
         OP_QUERY: begin
            s = locate(h, 1);
            if (s >= 0) begin
               e.ok     = tbl_rev[s];
               e.rights = tbl_rights[s];
            end
         end
         OP_CLOSE: begin
            s = locate(h, 1);
            if (s >= 0 && tbl_live != 0) begin
               release_slot(s);
               e.ok = 1;
            end
         end
         OP_REAP: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && tbl_occ[i] && tbl_rev[i]) begin
                  done = 1;
                  if (tbl_object[i] != 0 && tbl_live != 0) begin
                     e.object = tbl_object[i];
                     release_slot(i);
                     e.ok = 1;
                  end
               end
            end
         end
         default: ;
      endcase
      e.live    = tbl_live[7:0];
      e.revoked = tbl_revoked[7:0];
      return e;
   endfunction

   // called at a rising edge; returns at the edge where the word was taken
   task automatic send_word(input logic [2:0] op, input logic [63:0] h, input logic [63:0] obj,
                            input logic [2:0] kind, input logic [7:0] r, input logic ro);
      reply_type e;
      if (!quiet && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_handle_in       <= h;
      req_object_ref      <= obj;
      req_object_kind     <= kind;
      req_rights          <= r;
      req_object_readonly <= ro;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      e = table_step(op, h, obj, kind, r, ro);
      pending_replies.push_back(e);
      words_sent++;
      if (e.ok) words_ok++;
      if (op == OP_INSTALL && e.ok) begin
         issued_handles.push_back(e.handle);
         if (issued_handles.size() > 160) void'(issued_handles.pop_front());
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_TAG:    cfg_tag   = val;
         REG_MODE:   cfg_mode  = val[1:0];
         REG_RIGHTS: cfg_all   = val[7:0];
         REG_WRITE:  cfg_write = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_domain(input logic [31:0] tag, input logic [1:0] mode,
                             input logic [7:0] all, input logic [7:0] wr);
      write_reg(REG_TAG, tag);
      write_reg(REG_MODE, {30'd0, mode});
      write_reg(REG_RIGHTS, {24'd0, all});
      write_reg(REG_WRITE, {24'd0, wr});
      settings_seen++;
   endtask

   function automatic logic [63:0] pick_handle();
      int          x;
      logic [63:0] h;
      x = $urandom_range(99);
      if (issued_handles.size() != 0 && x < 72) begin
         h = issued_handles[$urandom_range(issued_handles.size() - 1)];
         if (x < 6) h ^= 64'd1 << $urandom_range(63);
      end else if (x < 88) begin
         h = {cfg_tag, 24'($urandom_range(0, 4)), 8'($urandom_range(0, 70))};
      end else begin
         h = {$urandom, $urandom};
      end
      return h;
   endfunction

   task automatic random_word;
      int          x;
      int          s;
      logic [2:0]  op;
      logic [63:0] h;
      logic [63:0] obj;
      logic [2:0]  kind;
      logic [7:0]  r;
      x = $urandom_range(99);
      if (x < ((tbl_live < 48) ? 28 : 6))  op = OP_INSTALL;
      else if (x < 46)                     op = OP_RESOLVE;
      else if (x < 58)                     op = OP_RESTRICT;
      else if (x < 70)                     op = OP_REVOKE;
      else if (x < 79)                     op = OP_QUERY;
      else if (x < 90)                     op = OP_CLOSE;
      else if (x < 98)                     op = OP_REAP;
      else                                 op = OP_NONE;
      h    = pick_handle();
      obj  = ($urandom_range(19) == 0) ? 64'd0 : {$urandom, $urandom};
      kind = ($urandom_range(9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom);
      r    = ($urandom_range(9) < 8) ? (8'($urandom) & cfg_all) : 8'($urandom);
      s    = locate(h, 0);
      // mostly well-formed follow-ups on live entries
      if (s >= 0 && $urandom_range(3) != 0) begin
         if (op == OP_RESOLVE) kind = $urandom_range(1) ? KIND_ANY : tbl_kind[s];
         if (op == OP_RESOLVE || op == OP_RESTRICT) r = tbl_rights[s] & 8'($urandom);
      end
      send_word(op, h, obj, kind, r, 1'($urandom_range(1)));
   endtask

   task automatic test_directed;
      logic [63:0] h1;
      logic [63:0] h2;
      send_word(OP_INSTALL, 0, 64'hffff_ffff_ffff_ffff, KIND_TENSOR, 8'hff, 0);
      h1 = issued_handles[$];
      send_word(OP_INSTALL, 0, 64'd1, KIND_GENERIC, 8'h01, 0);
      h2 = issued_handles[$];
      send_word(OP_INSTALL, 0, 64'd0, KIND_TENSOR, 8'h01, 0);
      send_word(OP_INSTALL, 0, 64'd5, KIND_NONE, 8'h01, 0);
      send_word(OP_INSTALL, 0, 64'd5, KIND_ANY, 8'h01, 0);
      send_word(OP_INSTALL, 0, 64'd5, KIND_TENSOR, 8'h00, 0);
      send_word(OP_INSTALL, 0, 64'd5, KIND_TENSOR, 8'h02, 1);  // readonly with write
      send_word(OP_INSTALL, 0, 64'd6, KIND_TENSOR, 8'h01, 1);
      send_word(OP_INSTALL, 0, 64'd7, KIND_BACKING, 8'h02, 1);
      send_word(OP_RESOLVE, h1, 0, KIND_ANY, 8'h00, 0);
      send_word(OP_RESOLVE, h1, 0, KIND_BACKING, 8'h01, 0);
      send_word(OP_RESOLVE, h1, 0, 3'd6, 8'h01, 0);
      send_word(OP_RESOLVE, h1, 0, KIND_TENSOR, 8'hff, 0);
      send_word(OP_RESOLVE, h2, 0, KIND_GENERIC, 8'h03, 0);
      send_word(OP_RESTRICT, h1, 0, 0, 8'h0f, 0);
      send_word(OP_RESTRICT, h1, 0, 0, 8'hff, 0);
      send_word(OP_RESTRICT, h1, 0, 0, 8'h00, 0);
      send_word(OP_RESOLVE, 64'd0, 0, KIND_ANY, 8'h00, 0);
      send_word(OP_RESOLVE, h1 ^ (64'd1 << 32), 0, KIND_ANY, 8'h00, 0);
      send_word(OP_RESOLVE, h1 & ~64'hff, 0, KIND_ANY, 8'h00, 0);
      send_word(OP_RESOLVE, h1 | 64'hff, 0, KIND_ANY, 8'h00, 0);
      send_word(OP_RESOLVE, h1 ^ (64'd1 << 8), 0, KIND_ANY, 8'h00, 0);
      send_word(OP_REVOKE, h1, 0, 0, 0, 0);
      send_word(OP_REVOKE, h1, 0, 0, 0, 0);
      send_word(OP_QUERY, h1, 0, 0, 0, 0);
      send_word(OP_RESOLVE, h1, 0, KIND_ANY, 8'h00, 0);
      send_word(OP_QUERY, h2, 0, 0, 0, 0);
      send_word(OP_REAP, 0, 0, 0, 0, 0);
      send_word(OP_REAP, 0, 0, 0, 0, 0);
      send_word(OP_CLOSE, h2, 0, 0, 0, 0);
      send_word(OP_CLOSE, h2, 0, 0, 0, 0);
      send_word(OP_NONE, h2, 64'd3, KIND_TENSOR, 8'h01, 0);
   endtask

   task automatic test_full_table;
      repeat (SLOTS + 2) send_word(OP_INSTALL, 0, {$urandom, $urandom}, 3'($urandom_range(1, 4)),
                                   8'($urandom_range(1, 255)), 0);
      repeat (24) send_word(OP_REVOKE, pick_handle(), 0, 0, 0, 0);
      repeat (14) send_word(OP_REAP, 0, 0, 0, 0, 0);
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_occ[i]) send_word(OP_CLOSE, {cfg_tag, tbl_gen[i], 8'(i + 1)}, 0, 0, 0, 0);
      end
   endtask

   task automatic test_domain_settings;
      set_domain(32'd0, 2'd0, 8'hff, 8'h02);
      repeat (40) random_word();
      set_domain(32'hffff_ffff, 2'd0, 8'h01, 8'h01);
      repeat (60) random_word();
      set_domain(32'hffff_ffff, 2'd1, 8'h81, 8'hff);
      repeat (40) random_word();
      set_domain(32'hffff_ffff, 2'd2, 8'hff, 8'h00);
      repeat (30) random_word();
      set_domain(32'hffff_ffff, 2'd3, 8'hff, 8'h00);
      repeat (30) random_word();
      set_domain(32'h5a5a_0001, 2'd0, 8'h7e, 8'h80);
      repeat (60) random_word();
   endtask

   task automatic test_random_traffic;
      set_domain($urandom, 2'd0, 8'hff, 8'h02);
      for (int n = 0; n < 1300; n++) begin
         quiet = (n >= 500 && n < 700);
         random_word();
      end
      quiet = 0;
   endtask

   always @(posedge clock) begin
      reply_type e;
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !quiet && ($urandom_range(99) < 24);
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_replies.size() == 0) begin
            report("response word with nothing expected");
         end else begin
            e = pending_replies.pop_front();
            if (rsp_ok !== e.ok)
               report($sformatf("ok %b, expected %b", rsp_ok, e.ok));
            if (rsp_handle_out !== e.handle)
               report($sformatf("handle %h, expected %h", rsp_handle_out, e.handle));
            if (rsp_object_out !== e.object)
               report($sformatf("object %h, expected %h", rsp_object_out, e.object));
            if (rsp_rights_out !== e.rights)
               report($sformatf("rights %h, expected %h", rsp_rights_out, e.rights));
            if (rsp_live_count !== e.live)
               report($sformatf("live %0d, expected %0d", rsp_live_count, e.live));
            if (rsp_revoked_count !== e.revoked)
               report($sformatf("revoked %0d, expected %0d", rsp_revoked_count, e.revoked));
         end
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tbl_object[i] = 0;
         tbl_gen[i]    = 24'd1;
         tbl_kind[i]   = KIND_NONE;
         tbl_rights[i] = 0;
         tbl_occ[i]    = 0;
         tbl_rev[i]    = 0;
      end
      tbl_live = 0;
      tbl_revoked = 0;
      cfg_tag = 32'd1;
      cfg_mode = 2'd0;
      cfg_all = 8'hff;
      cfg_write = 8'h02;
      quiet = 0;
      errors = 0;
      words_sent = 0;
      words_ok = 0;
      settings_seen = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_NONE;
      req_handle_in <= 0;
      req_object_ref <= 0;
      req_object_kind <= KIND_NONE;
      req_rights <= 0;
      req_object_readonly <= 0;
      csr_write <= 1'b0;
      csr_index <= REG_TAG;
      csr_wdata <= 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_domain_settings();
      test_random_traffic();
      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d words (%0d succeeded) over %0d domain settings",
               words_sent, words_ok, settings_seen);
      if (errors == 0 && pending_replies.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
